### src/dta_pkg.sv
// Shared types, codes and default sizes of the descriptor table allocator.
`default_nettype none

package dta_pkg;

  // Default sizes
  localparam int unsigned PROCS_DEF       = 16;
  localparam int unsigned SLOTS_DEF       = 6;
  localparam int unsigned OFFSET_BITS_DEF = 16;

  // Command codes
  typedef enum logic [2:0] {
    CMD_OPEN       = 3'd0,
    CMD_CLOSE      = 3'd1,
    CMD_CLOSE_PROC = 3'd2,
    CMD_COUNT      = 3'd3,
    CMD_DUP        = 3'd4,
    CMD_INHERIT    = 3'd5,
    CMD_SEEK       = 3'd6,
    CMD_TELL       = 3'd7
  } cmd_e;

  // Status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_TABLE = 3'd1,
    ST_NO_DESC  = 3'd2,
    ST_FULL     = 3'd3,
    ST_SOCKET   = 3'd4
  } status_e;

  // Result of one pass of the slot scan unit
  typedef struct packed {
    logic [2:0] free_idx;  // lowest free slot
    logic       full;      // no free slot
    logic       fd_ok;     // selected slot exists and is in use
    logic [3:0] count;     // used slots
  } slot_info_t;

endpackage

`default_nettype wire

### src/dta_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module dta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### src/dta_slot_unit.sv
// Slot scan unit: lowest free slot, used count and slot check of one table row.
`default_nettype none

module dta_slot_unit
  import dta_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  wire logic [SLOTS-1:0] mask_i,
  input  wire logic [2:0]       fd_i,
  output slot_info_t            info_o
);

  always_comb begin
    info_o = '0;
    info_o.full = &mask_i;
    // scan from the top so the lowest free slot wins
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!mask_i[s]) begin
        info_o.free_idx = 3'(s);
      end
    end
    for (int s = 0; s < SLOTS; s++) begin
      info_o.count = 4'(info_o.count + 4'(mask_i[s]));
      if (fd_i == 3'(s) && mask_i[s]) begin
        info_o.fd_ok = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/descriptor_table_allocator.sv
// Descriptor table allocator: top level with command sequencer and table storage.
//
// Keeps one descriptor table of SLOTS slots for each of PROCS processes. A
// request carries one command (open, close, close_process, count, dup,
// inherit, seek, tell) and yields exactly one result. The block works on one
// request at a time and deasserts in_ready_o until the sequencer is back in
// idle; a finished result sits in an output register, so the next request is
// taken while the previous result still waits for out_ready_i. A pid out of
// range goes straight to the result. Other commands read the source row;
// dup then reads the target row and the source entry, seek and tell the
// entry, and inherit checks each parent slot in turn and, for a used slot
// with a known target, places a copy if the target has room. Reads of the
// used-mask RAM and the attribute RAM are registered, and inherit walks the
// parent slots one by one through the shared slot scan unit, re-reading the
// parent row at every slot. The used masks live in a RAM with one valid bit
// per row in flops, so reset clears every table at once and no clearing pass
// is needed. Slot attributes (kind, mode, offset) live in a second RAM that
// is never cleared; only slots marked used are read from it.
`default_nettype none

module descriptor_table_allocator
  import dta_pkg::*;
#(
  parameter int unsigned PROCS       = PROCS_DEF,
  parameter int unsigned SLOTS       = SLOTS_DEF,
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [7:0]  pid_i,
  input  wire logic [2:0]  fd_number_i,
  input  wire logic [7:0]  target_pid_i,
  input  wire logic        is_socket_i,
  input  wire logic [1:0]  access_mode_i,
  input  wire logic [15:0] seek_target_i,
  input  wire logic [15:0] file_length_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [2:0]       slot_out_o,
  output logic [15:0]      value_out_o,
  output logic             entry_socket_o,
  output logic [1:0]       entry_mode_o
);

  localparam int unsigned PID_W      = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int unsigned ROWS       = 1 << PID_W;
  localparam int unsigned SW         = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned ATTR_W     = 3 + OFFSET_BITS;
  localparam int unsigned ATTR_DEPTH = PROCS << SW;
  localparam int unsigned ATTR_AW    = PID_W + SW;

  // one-hot sequencer
  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_SRC     = 8'b0000_0010,  // source row read back
    S_ATTR    = 8'b0000_0100,  // seek / tell entry read back
    S_DUP     = 8'b0000_1000,  // dup: target row and source entry read back
    S_INH_RD  = 8'b0001_0000,  // inherit: re-read parent row
    S_INH_CHK = 8'b0010_0000,  // inherit: check one parent slot
    S_INH_WR  = 8'b0100_0000,  // inherit: place the copy
    S_DONE    = 8'b1000_0000   // result ready for the output register
  } state_e;

  state_e state_q, state_d;

  // latched request
  cmd_e             cmd_q, cmd_d;
  logic [PID_W-1:0] pid_q, pid_d;
  logic [PID_W-1:0] tgt_q, tgt_d;
  logic             tgt_ok_q, tgt_ok_d;
  logic [2:0]       fd_q, fd_d;
  logic             sock_q, sock_d;
  logic [1:0]       mode_q, mode_d;
  logic [15:0]      seek_q, seek_d;
  logic [15:0]      flen_q, flen_d;

  // inherit walk
  logic [2:0] slot_q, slot_d;
  logic [3:0] cnt_q, cnt_d;

  // pending result
  status_e     res_status_q, res_status_d;
  logic [2:0]  res_slot_q, res_slot_d;
  logic [15:0] res_value_q, res_value_d;
  logic        res_sock_q, res_sock_d;
  logic [1:0]  res_mode_q, res_mode_d;

  // output register
  logic        out_valid_q, out_valid_d;
  status_e     out_status_q, out_status_d;
  logic [2:0]  out_slot_q, out_slot_d;
  logic [15:0] out_value_q, out_value_d;
  logic        out_sock_q, out_sock_d;
  logic [1:0]  out_mode_q, out_mode_d;

  // used-mask RAM and its row valid bits
  logic              used_we;
  logic [PID_W-1:0]  used_waddr, used_raddr;
  logic [SLOTS-1:0]  used_wdata, used_rdata, used_mask;
  logic [ROWS-1:0]   row_vld_q, row_vld_d;
  logic              rd_vld_q;

  // attribute RAM: {socket, mode, offset}
  logic               attr_we;
  logic [ATTR_AW-1:0] attr_waddr, attr_raddr;
  logic [ATTR_W-1:0]  attr_wdata, attr_rdata;

  // shared slot scan unit
  logic [2:0]       unit_fd;
  slot_info_t       info;
  logic [SLOTS-1:0] free_bit, fd_bit;

  logic        pid_ok_i, out_free;
  logic [15:0] clamp16;
  logic [31:0] clamp32, off32;

  assign pid_ok_i = 32'(pid_i) < 32'(PROCS);
  assign out_free = !out_valid_q || out_ready_i;

  // a row never written reads as all slots free
  assign used_mask = used_rdata & {SLOTS{rd_vld_q}};

  assign free_bit = SLOTS'(1) << info.free_idx;
  assign fd_bit   = SLOTS'(1) << fd_q;

  assign clamp16 = (seek_q > flen_q) ? flen_q : seek_q;
  assign clamp32 = 32'(clamp16);
  assign off32   = 32'(attr_rdata[OFFSET_BITS-1:0]);

  dta_ram #(
    .WIDTH (SLOTS),
    .DEPTH (PROCS)
  ) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_waddr),
    .wdata_i (used_wdata),
    .raddr_i (used_raddr),
    .rdata_o (used_rdata)
  );

  dta_ram #(
    .WIDTH (ATTR_W),
    .DEPTH (ATTR_DEPTH)
  ) u_attr_ram (
    .clk_i   (clk_i),
    .we_i    (attr_we),
    .waddr_i (attr_waddr),
    .wdata_i (attr_wdata),
    .raddr_i (attr_raddr),
    .rdata_o (attr_rdata)
  );

  dta_slot_unit #(
    .SLOTS (SLOTS)
  ) u_slot_unit (
    .mask_i (used_mask),
    .fd_i   (unit_fd),
    .info_o (info)
  );

  assign unit_fd = (cmd_q == CMD_INHERIT) ? slot_q : fd_q;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    pid_d        = pid_q;
    tgt_d        = tgt_q;
    tgt_ok_d     = tgt_ok_q;
    fd_d         = fd_q;
    sock_d       = sock_q;
    mode_d       = mode_q;
    seek_d       = seek_q;
    flen_d       = flen_q;
    slot_d       = slot_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_value_d  = res_value_q;
    res_sock_d   = res_sock_q;
    res_mode_d   = res_mode_q;
    row_vld_d    = row_vld_q;

    in_ready_o = 1'b0;
    used_we    = 1'b0;
    used_waddr = pid_q;
    used_wdata = used_mask | free_bit;
    used_raddr = pid_q;
    attr_we    = 1'b0;
    attr_waddr = {pid_q, info.free_idx[SW-1:0]};
    attr_wdata = {sock_q, mode_q, clamp32[OFFSET_BITS-1:0]};
    attr_raddr = {pid_q, fd_q[SW-1:0]};

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        used_raddr = pid_i[PID_W-1:0];
        if (in_valid_i) begin
          cmd_d        = cmd_e'(cmd_i);
          pid_d        = pid_i[PID_W-1:0];
          tgt_d        = target_pid_i[PID_W-1:0];
          tgt_ok_d     = 32'(target_pid_i) < 32'(PROCS);
          fd_d         = fd_number_i;
          sock_d       = is_socket_i;
          mode_d       = access_mode_i;
          seek_d       = seek_target_i;
          flen_d       = file_length_i;
          slot_d       = '0;
          cnt_d        = '0;
          res_status_d = ST_OK;
          res_slot_d   = '0;
          res_value_d  = '0;
          res_sock_d   = 1'b0;
          res_mode_d   = '0;
          if (!pid_ok_i) begin
            res_status_d = ST_NO_TABLE;
            state_d      = S_DONE;
          end else if (cmd_e'(cmd_i) == CMD_INHERIT) begin
            state_d = S_INH_CHK;
          end else begin
            state_d = S_SRC;
          end
        end
      end

      S_SRC: begin
        state_d = S_DONE;
        case (cmd_q)
          CMD_OPEN: begin
            if (info.full) begin
              res_status_d = ST_FULL;
            end else begin
              used_we    = 1'b1;
              attr_we    = 1'b1;
              attr_wdata = {sock_q, mode_q, {OFFSET_BITS{1'b0}}};
              res_slot_d = info.free_idx;
            end
          end
          CMD_CLOSE: begin
            if (!info.fd_ok) begin
              res_status_d = ST_NO_DESC;
            end else begin
              used_we    = 1'b1;
              used_wdata = used_mask & ~fd_bit;
            end
          end
          CMD_CLOSE_PROC: begin
            res_value_d = 16'(info.count);
            used_we     = 1'b1;
            used_wdata  = '0;
          end
          CMD_COUNT: begin
            res_value_d = 16'(info.count);
          end
          CMD_DUP: begin
            if (!info.fd_ok) begin
              res_status_d = ST_NO_DESC;
            end else if (!tgt_ok_q) begin
              res_status_d = ST_NO_TABLE;
            end else begin
              used_raddr = tgt_q;
              state_d    = S_DUP;
            end
          end
          CMD_SEEK, CMD_TELL: begin
            if (!info.fd_ok) begin
              res_status_d = ST_NO_DESC;
            end else begin
              state_d = S_ATTR;
            end
          end
          default: ;
        endcase
      end

      S_ATTR: begin
        state_d = S_DONE;
        if (cmd_q == CMD_SEEK) begin
          if (attr_rdata[ATTR_W-1]) begin
            res_status_d = ST_SOCKET;
          end else begin
            attr_we    = 1'b1;
            attr_waddr = {pid_q, fd_q[SW-1:0]};
            attr_wdata = {attr_rdata[ATTR_W-1 -: 3], clamp32[OFFSET_BITS-1:0]};
          end
        end else begin
          res_value_d = off32[15:0];
          res_sock_d  = attr_rdata[ATTR_W-1];
          res_mode_d  = attr_rdata[ATTR_W-2 -: 2];
        end
      end

      S_DUP: begin
        state_d = S_DONE;
        if (info.full) begin
          res_status_d = ST_FULL;
        end else begin
          used_we    = 1'b1;
          used_waddr = tgt_q;
          attr_we    = 1'b1;
          attr_waddr = {tgt_q, info.free_idx[SW-1:0]};
          attr_wdata = attr_rdata;
          res_slot_d = info.free_idx;
        end
      end

      S_INH_RD: begin
        state_d = S_INH_CHK;
      end

      S_INH_CHK: begin
        attr_raddr = {pid_q, slot_q[SW-1:0]};
        if (info.fd_ok && tgt_ok_q) begin
          used_raddr = tgt_q;
          state_d    = S_INH_WR;
        end else if (slot_q == 3'(SLOTS - 1)) begin
          res_value_d = 16'(cnt_q);
          state_d     = S_DONE;
        end else begin
          slot_d  = 3'(slot_q + 3'd1);
          state_d = S_INH_RD;
        end
      end

      S_INH_WR: begin
        if (!info.full) begin
          used_we    = 1'b1;
          used_waddr = tgt_q;
          attr_we    = 1'b1;
          attr_waddr = {tgt_q, info.free_idx[SW-1:0]};
          attr_wdata = attr_rdata;
          cnt_d      = 4'(cnt_q + 4'd1);
        end
        // parent row is re-read next cycle, after this write has landed
        if (slot_q == 3'(SLOTS - 1)) begin
          res_value_d = 16'(cnt_d);
          state_d     = S_DONE;
        end else begin
          slot_d  = 3'(slot_q + 3'd1);
          state_d = S_INH_RD;
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (used_we) begin
      row_vld_d[used_waddr] = 1'b1;
    end
  end

  // output register
  always_comb begin
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_value_d  = out_value_q;
    out_sock_d   = out_sock_q;
    out_mode_d   = out_mode_q;
    if (state_q == S_DONE && out_free) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_slot_d   = res_slot_q;
      out_value_d  = res_value_q;
      out_sock_d   = res_sock_q;
      out_mode_d   = res_mode_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      row_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      row_vld_q   <= row_vld_d;
      rd_vld_q    <= row_vld_q[used_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    pid_q        <= pid_d;
    tgt_q        <= tgt_d;
    tgt_ok_q     <= tgt_ok_d;
    fd_q         <= fd_d;
    sock_q       <= sock_d;
    mode_q       <= mode_d;
    seek_q       <= seek_d;
    flen_q       <= flen_d;
    slot_q       <= slot_d;
    cnt_q        <= cnt_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_value_q  <= res_value_d;
    res_sock_q   <= res_sock_d;
    res_mode_q   <= res_mode_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_value_q  <= out_value_d;
    out_sock_q   <= out_sock_d;
    out_mode_q   <= out_mode_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign slot_out_o     = out_slot_q;
  assign value_out_o    = out_value_q;
  assign entry_socket_o = out_sock_q;
  assign entry_mode_o   = out_mode_q;

endmodule

`default_nettype wire

### src/dta_checker.sv
// Port-level checker for the descriptor table allocator, bound to the top level.
`default_nettype none

module dta_checker
  import dta_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  status_o,
  input wire logic [2:0]  slot_out_o,
  input wire logic [15:0] value_out_o,
  input wire logic        entry_socket_o,
  input wire logic [1:0]  entry_mode_o
);

  // a waiting result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(slot_out_o) && $stable(value_out_o) && $stable(entry_socket_o) &&
      $stable(entry_mode_o))
    else $error("result changed while stalled");

  // one request at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

  // status code in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_SOCKET)
    else $error("status code out of range");

  // error results carry nothing but the status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> slot_out_o == 3'd0 &&
      value_out_o == 16'd0 && !entry_socket_o && entry_mode_o == 2'd0)
    else $error("error result with nonzero fields");

endmodule

bind descriptor_table_allocator dta_checker u_dta_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .slot_out_o     (slot_out_o),
  .value_out_o    (value_out_o),
  .entry_socket_o (entry_socket_o),
  .entry_mode_o   (entry_mode_o)
);

`default_nettype wire

### bench/tb_descriptor_table_allocator.sv
// Self-checking testbench for the per-process descriptor table allocator.
module tb_descriptor_table_allocator
  import dta_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_REQUESTS = 1350;
  // Accepted-request counts at which the idle pattern changes
  localparam int unsigned PHASE1_AT = 460;
  localparam int unsigned PHASE2_AT = 920;
  // Long result-side stall: starts at this accept count, lasts this many cycles
  localparam int unsigned HOLD_AT     = 300;
  localparam int unsigned HOLD_CYCLES = 250;
  // Slowest command (inherit) plus margin, waited out at the end
  localparam int unsigned DRAIN_CYCLES = 3 * SLOTS_DEF + 12;
  localparam int unsigned MAX_REPORTS  = 10;

  // One request as offered on the input channel; wait_drain holds it back
  // until every outstanding result has come out.
  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  pid;
    logic [2:0]  fd;
    logic [7:0]  tgt;
    logic        sock;
    logic [1:0]  mode;
    logic [15:0] seek_t;
    logic [15:0] flen;
    logic        wait_drain;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  slot;
    logic [15:0] value;
    logic        esock;
    logic [1:0]  emode;
  } result_t;

  typedef struct packed {
    logic        sock;
    logic [1:0]  mode;
    logic [15:0] offset;
  } fd_attr_t;

  // DUT signals
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [2:0]  cmd_i;
  logic [7:0]  pid_i;
  logic [2:0]  fd_number_i;
  logic [7:0]  target_pid_i;
  logic        is_socket_i;
  logic [1:0]  access_mode_i;
  logic [15:0] seek_target_i;
  logic [15:0] file_length_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [2:0]  slot_out_o;
  logic [15:0] value_out_o;
  logic        entry_socket_o;
  logic [1:0]  entry_mode_o;

  // Request currently on the bus; its fields drive the ports directly
  req_t        cur_req = '0;

  // Shadow copy of the descriptor tables
  logic [SLOTS_DEF-1:0] slot_used [PROCS_DEF];
  fd_attr_t             slot_attr [PROCS_DEF][SLOTS_DEF];

  req_t        request_q[$];        // stimulus not yet offered
  result_t     pending_results[$];  // predicted results, oldest first
  logic        req_taken    = 1'b0; // request accepted at the last rising edge
  int unsigned accepted_cnt = 0;
  int unsigned mismatches   = 0;
  int unsigned hold_left    = 0;
  logic        hold_done    = 1'b0;

  assign cmd_i         = cur_req.cmd;
  assign pid_i         = cur_req.pid;
  assign fd_number_i   = cur_req.fd;
  assign target_pid_i  = cur_req.tgt;
  assign is_socket_i   = cur_req.sock;
  assign access_mode_i = cur_req.mode;
  assign seek_target_i = cur_req.seek_t;
  assign file_length_i = cur_req.flen;

  descriptor_table_allocator uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .pid_i          (pid_i),
    .fd_number_i    (fd_number_i),
    .target_pid_i   (target_pid_i),
    .is_socket_i    (is_socket_i),
    .access_mode_i  (access_mode_i),
    .seek_target_i  (seek_target_i),
    .file_length_i  (file_length_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .slot_out_o     (slot_out_o),
    .value_out_o    (value_out_o),
    .entry_socket_o (entry_socket_o),
    .entry_mode_o   (entry_mode_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Lowest free slot of table p, -1 when full
  function automatic int first_free(logic [7:0] p);
    for (int s = 0; s < SLOTS_DEF; s++) begin
      if (!slot_used[p][s]) return s;
    end
    return -1;
  endfunction

  // Slot exists and is open; p must already be a known table
  function automatic logic fd_live(logic [7:0] p, logic [2:0] fd);
    return (fd < SLOTS_DEF) && slot_used[p][fd];
  endfunction

  // Copy descriptor s of table src into the lowest free slot of table dst.
  // Source errors win over destination errors.
  function automatic status_e copy_fd(input logic [7:0] src, input logic [2:0] s,
                                      input logic [7:0] dst, output logic [2:0] slot);
    int f;
    slot = '0;
    if (src >= PROCS_DEF) return ST_NO_TABLE;
    if (!fd_live(src, s)) return ST_NO_DESC;
    if (dst >= PROCS_DEF) return ST_NO_TABLE;
    f = first_free(dst);
    if (f < 0) return ST_FULL;
    slot_attr[dst][f] = slot_attr[src][s];
    slot_used[dst][f] = 1'b1;
    slot = 3'(f);
    return ST_OK;
  endfunction

  // Applies one accepted request to the shadow tables and returns its result.
  // Fields a command does not define stay zero, as does everything but the
  // status on an error.
  function automatic result_t apply_request(req_t rq);
    result_t    res;
    logic [2:0] scratch;
    int         f;
    res = '0;
    res.status = ST_OK;
    if (rq.pid >= PROCS_DEF) begin
      res.status = ST_NO_TABLE;
    end else begin
      case (rq.cmd)
        CMD_OPEN: begin
          f = first_free(rq.pid);
          if (f < 0) begin
            res.status = ST_FULL;
          end else begin
            slot_attr[rq.pid][f] = '{sock: rq.sock, mode: rq.mode, offset: '0};
            slot_used[rq.pid][f] = 1'b1;
            res.slot = 3'(f);
          end
        end
        CMD_CLOSE: begin
          if (!fd_live(rq.pid, rq.fd)) res.status = ST_NO_DESC;
          else slot_used[rq.pid][rq.fd] = 1'b0;
        end
        CMD_CLOSE_PROC, CMD_COUNT: begin
          res.value = 16'($countones(slot_used[rq.pid]));
          if (rq.cmd == CMD_CLOSE_PROC) slot_used[rq.pid] = '0;
        end
        CMD_DUP: begin
          res.status = copy_fd(rq.pid, rq.fd, rq.tgt, res.slot);
        end
        CMD_INHERIT: begin
          // Live table is re-read at each slot, so a self-inherit keeps
          // copying its own new entries until the table fills.
          for (int s = 0; s < SLOTS_DEF; s++) begin
            if (slot_used[rq.pid][s] && copy_fd(rq.pid, 3'(s), rq.tgt, scratch) == ST_OK)
              res.value = res.value + 16'd1;
          end
        end
        CMD_SEEK: begin
          if (!fd_live(rq.pid, rq.fd)) res.status = ST_NO_DESC;
          else if (slot_attr[rq.pid][rq.fd].sock) res.status = ST_SOCKET;
          else slot_attr[rq.pid][rq.fd].offset =
                 (rq.seek_t > rq.flen) ? rq.flen : rq.seek_t;
        end
        default: begin  // CMD_TELL
          if (!fd_live(rq.pid, rq.fd)) begin
            res.status = ST_NO_DESC;
          end else begin
            res.value = slot_attr[rq.pid][rq.fd].offset;
            res.esock = slot_attr[rq.pid][rq.fd].sock;
            res.emode = slot_attr[rq.pid][rq.fd].mode;
          end
        end
      endcase
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic void queue_request(cmd_e c, int p, int fd = 0, int tgt = 0,
                                        int sock = 0, int mode = 0,
                                        int seek_t = 0, int flen = 0);
    req_t rq;
    rq = '0;
    rq.cmd    = c;
    rq.pid    = 8'(p);
    rq.fd     = 3'(fd);
    rq.tgt    = 8'(tgt);
    rq.sock   = 1'(sock);
    rq.mode   = 2'(mode);
    rq.seek_t = 16'(seek_t);
    rq.flen   = 16'(flen);
    request_q.push_back(rq);
  endfunction

  // Mostly known tables and open-range slots, so commands reach real entries;
  // the rest draw ids from the whole 8-bit range and slot numbers beyond the table.
  function automatic req_t random_request();
    req_t        rq;
    int unsigned pick;
    rq   = '0;
    pick = $urandom_range(0, 99);
    if (pick < 28)      rq.cmd = CMD_OPEN;
    else if (pick < 40) rq.cmd = CMD_CLOSE;
    else if (pick < 44) rq.cmd = CMD_CLOSE_PROC;
    else if (pick < 50) rq.cmd = CMD_COUNT;
    else if (pick < 62) rq.cmd = CMD_DUP;
    else if (pick < 67) rq.cmd = CMD_INHERIT;
    else if (pick < 83) rq.cmd = CMD_SEEK;
    else                rq.cmd = CMD_TELL;
    rq.pid = ($urandom_range(0, 99) < 88) ? 8'($urandom_range(0, PROCS_DEF - 1))
                                          : 8'($urandom_range(0, 255));
    rq.tgt = ($urandom_range(0, 99) < 88) ? 8'($urandom_range(0, PROCS_DEF - 1))
                                          : 8'($urandom_range(0, 255));
    rq.fd  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(SLOTS_DEF, 7))
                                         : 3'($urandom_range(0, SLOTS_DEF - 1));
    rq.sock = ($urandom_range(0, 3) == 0);
    rq.mode = 2'($urandom_range(0, 3));
    rq.seek_t = 16'($urandom_range(0, 16'hFFFF));
    rq.flen   = 16'($urandom_range(0, 16'hFFFF));
    case ($urandom_range(0, 5))
      0: rq.seek_t = rq.flen;     // exactly at the end
      1: rq.seek_t = 16'hFFFF;
      2: rq.flen   = 16'h0000;
      default: ;
    endcase
    return rq;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: new request at the falling edge once the previous one is taken
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin : drive_requests
    logic        offer;
    int unsigned idle_pct;
    offer    = in_valid_i && !req_taken;  // still waiting for acceptance
    idle_pct = (accepted_cnt < PHASE1_AT) ? 32 : (accepted_cnt < PHASE2_AT) ? 68 : 0;
    if (!offer && rst_ni && request_q.size() != 0) begin
      if (request_q[0].wait_drain && pending_results.size() != 0) begin
        offer = 1'b0;  // hold back until the block has emptied out
      end else if ($urandom_range(0, 99) >= idle_pct) begin
        cur_req <= request_q.pop_front();
        offer = 1'b1;
      end
    end
    in_valid_i <= offer;
  end

  // Result-side ready: random stalls, forced low during the long hold
  always @(negedge clk_i) begin : drive_ready
    int unsigned stall_pct;
    stall_pct = (accepted_cnt < PHASE1_AT) ? 68 : (accepted_cnt < PHASE2_AT) ? 32 : 0;
    if (hold_left != 0) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Long hold: the block fills its output register and then stalls its input
  // while the driver keeps offering.
  always @(negedge clk_i) begin : long_hold
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (accepted_cnt == HOLD_AT && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on request acceptance, checks on result acceptance
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : monitor
    result_t want;
    if (rst_ni) begin
      req_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        pending_results.push_back(apply_request(cur_req));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t ns: result with no request outstanding: status=%0d slot=%0d value=%0d",
                     $time, status_o, slot_out_o, value_out_o);
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status || slot_out_o !== want.slot ||
              value_out_o !== want.value || entry_socket_o !== want.esock ||
              entry_mode_o !== want.emode) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t ns: result mismatch: expected status=%0d slot=%0d value=%0d %s",
                       $time, want.status, want.slot, want.value, "");
              $display("    expected sock=%0b mode=%0d", want.esock, want.emode);
              $display("    got status=%0d slot=%0d value=%0d sock=%0b mode=%0d",
                       status_o, slot_out_o, value_out_o, entry_socket_o, entry_mode_o);
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : run
    req_t rq;
    for (int p = 0; p < PROCS_DEF; p++) slot_used[p] = '0;

    // Directed part
    queue_request(CMD_COUNT, 0);                          // empty table
    queue_request(CMD_OPEN, 0, 0, 0, 0, 0);               // file, read -> slot 0
    queue_request(CMD_OPEN, 0, 0, 0, 1, 3);               // socket, rw -> slot 1
    queue_request(CMD_SEEK, 0, 0, 0, 0, 0, 16'hFFFF, 16'h1234);  // clamped to length
    queue_request(CMD_TELL, 0, 0);
    queue_request(CMD_SEEK, 0, 1, 0, 0, 0, 16'h0010, 16'hFFFF);  // socket refused
    queue_request(CMD_TELL, 0, 1);
    queue_request(CMD_SEEK, 0, 0, 0, 0, 0, 16'h0005, 16'hFFFF);  // below length
    queue_request(CMD_TELL, 0, 7);                        // slot beyond table
    queue_request(CMD_CLOSE, 0, 5);                       // slot not open
    queue_request(CMD_OPEN, 255);                         // unknown table
    queue_request(CMD_COUNT, 16);                         // unknown table, first out of range
    queue_request(CMD_DUP, 0, 0, 15);
    queue_request(CMD_DUP, 0, 4, 200);                    // bad source and bad target
    queue_request(CMD_DUP, 0, 0, 255);                    // bad target only
    for (int k = 1; k <= 5; k++) queue_request(CMD_OPEN, 15, 0, 0, k & 1, k & 3);
    queue_request(CMD_OPEN, 15);                          // table full
    queue_request(CMD_DUP, 0, 1, 15);                     // dup into full table
    queue_request(CMD_INHERIT, 0, 0, 0);                  // inherit into itself
    queue_request(CMD_INHERIT, 0, 0, 200);                // unknown target: ok, zero copies
    queue_request(CMD_INHERIT, 15, 0, 3);
    queue_request(CMD_TELL, 3, 5);
    queue_request(CMD_CLOSE_PROC, 0);
    queue_request(CMD_COUNT, 0);
    queue_request(CMD_CLOSE, 3, 0);
    queue_request(CMD_COUNT, 3);

    // Random part; two requests wait for the block to drain first
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      rq = random_request();
      if (i == 0 || i == 700) rq.wait_drain = 1'b1;
      request_q.push_back(rq);
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || in_valid_i || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0d predicted results never arrived", pending_results.size());
    end
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
